[src/i2c_bus_monitor_decoder_macros.svh]
// Assertion macros for the I2C bus monitor decoder.
// Used by the top level; depends on signals named clock and reset in scope.
`ifndef I2C_BUS_MONITOR_DECODER_MACROS_SVH
`define I2C_BUS_MONITOR_DECODER_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define I2CMON_ASSERT_NOW(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("i2cmon: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define I2CMON_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("i2cmon: next-cycle check failed");

`endif

[src/i2cmon_pkg.sv]
// Shared types and constants for the I2C bus monitor decoder.
// No dependencies; imported by every module of the block.
package i2cmon_pkg;

   localparam int CAPTURE_DEPTH_DEFAULT = 16384;
   localparam int INDEX_W = 14;
   localparam int TIME_W = 32;
   localparam int BYTE_W = 8;
   localparam int BITS_W = 4;
   localparam logic [BITS_W-1:0] BYTE_BITS = BITS_W'(8);
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      EV_START = 2'd0,
      EV_STOP  = 2'd1,
      EV_BYTE  = 2'd2,
      EV_ACK   = 2'd3
   } event_kind_type;

   // One line sample.
   typedef struct packed {
      logic              capture_first;
      logic              sda_level;
      logic              scl_level;
      logic [TIME_W-1:0] time_stamp;
   } req_type;

   // One decoded bus event.
   typedef struct packed {
      event_kind_type     event_kind;
      logic               is_address;
      logic [BYTE_W-1:0]  byte_value;
      logic               nak;
      logic [INDEX_W-1:0] sample_index;
      logic [TIME_W-1:0]  event_time;
   } rsp_type;

   // Compact event record held in the queue; flag is is_address or nak.
   typedef struct packed {
      event_kind_type     kind;
      logic               flag;
      logic [BYTE_W-1:0]  value;
      logic [INDEX_W-1:0] index;
      logic [TIME_W-1:0]  stamp;
   } entry_type;

   // Queue status seen by the top level and the back.
   typedef struct packed {
      logic [QCNT_W-1:0] count;
      logic              full;
      logic              empty;
   } qstat_type;

endpackage

[src/i2cmon_front.sv]
// Front end: accepts line samples, tracks the I2C decoder state and
// classifies each sample into at most one event. Depends on i2cmon_pkg.
module i2cmon_front
   import i2cmon_pkg::*;
#(
   parameter int CAPTURE_DEPTH = CAPTURE_DEPTH_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      accept,
   input  req_type   sample,
   output logic      push,
   output entry_type entry
);

   localparam int CNT_W = (CAPTURE_DEPTH > 2) ? $clog2(CAPTURE_DEPTH) : 1;
   localparam int EXT_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CAPTURE_DEPTH - 1);

   logic              last_sda_ff, last_sda_in;
   logic              last_scl_ff, last_scl_in;
   logic [BYTE_W-1:0] shift_ff, shift_in;
   logic [BITS_W-1:0] bits_ff, bits_in;
   logic              in_transfer_ff, in_transfer_in;
   logic              address_seen_ff, address_seen_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   logic              cur_last_sda;
   logic              cur_last_scl;
   logic [BYTE_W-1:0] cur_shift;
   logic [BITS_W-1:0] cur_bits;
   logic              cur_in_transfer;
   logic              cur_address_seen;
   logic [CNT_W-1:0]  cur_count;
   logic [EXT_W-1:0]  index_wide;
   logic              is_start;
   logic              is_stop;
   logic              is_rise;
   logic              has_event;

   // A capture mark makes this sample see the reset state.
   always_comb begin
      if (sample.capture_first) begin
         cur_last_sda     = 1'b1;
         cur_last_scl     = 1'b1;
         cur_shift        = '0;
         cur_bits         = '0;
         cur_in_transfer  = 1'b0;
         cur_address_seen = 1'b0;
         cur_count        = '0;
      end else begin
         cur_last_sda     = last_sda_ff;
         cur_last_scl     = last_scl_ff;
         cur_shift        = shift_ff;
         cur_bits         = bits_ff;
         cur_in_transfer  = in_transfer_ff;
         cur_address_seen = address_seen_ff;
         cur_count        = count_ff;
      end
   end

   // Bus conditions, in priority order start, stop, clock rise.
   assign is_start = cur_last_sda & ~sample.sda_level & sample.scl_level;
   assign is_stop  = ~cur_last_sda & sample.sda_level & sample.scl_level;
   assign is_rise  = cur_in_transfer & ~cur_last_scl & sample.scl_level;
   assign index_wide = EXT_W'(cur_count);

   // Next decoder state and the event record for this sample.
   always_comb begin
      last_sda_in     = sample.sda_level;
      last_scl_in     = sample.scl_level;
      shift_in        = cur_shift;
      bits_in         = cur_bits;
      in_transfer_in  = cur_in_transfer;
      address_seen_in = cur_address_seen;
      count_in        = (cur_count == CNT_LAST) ? '0 : cur_count + CNT_W'(1);
      has_event       = 1'b0;
      entry.kind      = EV_START;
      entry.flag      = 1'b0;
      entry.value     = '0;
      entry.index     = index_wide[INDEX_W-1:0];
      entry.stamp     = sample.time_stamp;
      if (is_start) begin
         has_event       = 1'b1;
         entry.kind      = EV_START;
         in_transfer_in  = 1'b1;
         address_seen_in = 1'b0;
         shift_in        = '0;
         bits_in         = '0;
      end else if (is_stop) begin
         has_event      = 1'b1;
         entry.kind     = EV_STOP;
         in_transfer_in = 1'b0;
      end else if (is_rise) begin
         if (cur_bits < BYTE_BITS) begin
            shift_in = {cur_shift[BYTE_W-2:0], sample.sda_level};
            bits_in  = cur_bits + BITS_W'(1);
            if (bits_in == BYTE_BITS) begin
               has_event   = 1'b1;
               entry.kind  = EV_BYTE;
               entry.flag  = ~cur_address_seen;
               entry.value = shift_in;
            end
         end else begin
            has_event       = 1'b1;
            entry.kind      = EV_ACK;
            entry.flag      = sample.sda_level;
            address_seen_in = 1'b1;
            shift_in        = '0;
            bits_in         = '0;
         end
      end
   end

   assign push = accept & has_event;

   // Decoder state advances once per accepted sample.
   always_ff @(posedge clock) begin
      if (reset) begin
         last_sda_ff     <= 1'b1;
         last_scl_ff     <= 1'b1;
         shift_ff        <= '0;
         bits_ff         <= '0;
         in_transfer_ff  <= 1'b0;
         address_seen_ff <= 1'b0;
         count_ff        <= '0;
      end else if (accept) begin
         last_sda_ff     <= last_sda_in;
         last_scl_ff     <= last_scl_in;
         shift_ff        <= shift_in;
         bits_ff         <= bits_in;
         in_transfer_ff  <= in_transfer_in;
         address_seen_ff <= address_seen_in;
         count_ff        <= count_in;
      end
   end

endmodule

[src/i2cmon_queue.sv]
// Short event queue between the decoder front end and the output stage.
// Depends on i2cmon_pkg.
module i2cmon_queue
   import i2cmon_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   input  logic      pop,
   output entry_type head,
   output qstat_type stat
);

   entry_type         slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   assign stat.count = count_ff;
   assign stat.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign stat.empty = (count_ff == '0);
   assign head       = slot_ff[rd_ptr_ff];

   // Pointer and fill count updates; pointers wrap at the queue depth.
   always_comb begin
      do_push   = push & ~stat.full;
      do_pop    = pop & ~stat.empty;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      count_in = count_ff + QCNT_W'(do_push) - QCNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

[src/i2cmon_back.sv]
// Back end: takes events from the queue, expands them into result fields
// and holds them in the output register. Depends on i2cmon_pkg.
module i2cmon_back
   import i2cmon_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  entry_type head,
   input  qstat_type stat,
   output logic      pop,
   output logic      rsp_valid,
   input  logic      rsp_ready,
   output rsp_type   rsp_data
);

   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff, out_data_in;

   // Load the output register whenever it is empty or being drained.
   assign pop = ~stat.empty & (~out_valid_ff | rsp_ready);

   // Expand the queue record; flags only count for their own event kinds.
   always_comb begin
      out_data_in.event_kind   = head.kind;
      out_data_in.is_address   = (head.kind == EV_BYTE) & head.flag;
      out_data_in.byte_value   = head.value;
      out_data_in.nak          = (head.kind == EV_ACK) & head.flag;
      out_data_in.sample_index = head.index;
      out_data_in.event_time   = head.stamp;
      if (pop) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

[src/i2c_bus_monitor_decoder.sv]
// I2C bus monitor decoder, top level: front end, event queue, output stage.
// Depends on i2cmon_pkg, i2cmon_front, i2cmon_queue, i2cmon_back and the macro header.
//
//   Channel  Direction  Handshake             Payload
//   req      in         req_valid/req_ready   req_data (req_type), one line sample
//   rsp      out        rsp_valid/rsp_ready   rsp_data (rsp_type), one bus event
//
// One sample is taken per cycle while the queue has room; the decoder state update in the
// front end sets that rate. Events pass through a queue slot, then the output register.
// Reset returns the lines to idle high, clears the decoder and empties queue and output.
// req_ready falls only while the four-entry event queue is full.
`include "i2c_bus_monitor_decoder_macros.svh"

module i2c_bus_monitor_decoder
   import i2cmon_pkg::*;
#(
   parameter int CAPTURE_DEPTH = CAPTURE_DEPTH_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic      accept;
   logic      push;
   logic      pop;
   entry_type push_entry;
   entry_type head;
   qstat_type stat;

   // A sample is taken whenever the queue has room for its event.
   assign req_ready = ~stat.full;
   assign accept    = req_valid & req_ready;

   i2cmon_front #(
      .CAPTURE_DEPTH(CAPTURE_DEPTH)
   ) u_front (
      .clock (clock),
      .reset (reset),
      .accept(accept),
      .sample(req_data),
      .push  (push),
      .entry (push_entry)
   );

   i2cmon_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_entry(push_entry),
      .pop       (pop),
      .head      (head),
      .stat      (stat)
   );

   i2cmon_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .stat     (stat),
      .pop      (pop),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   // The fill count never passes the queue depth.
   `I2CMON_ASSERT_NOW(a_queue_bound, 1'b1, stat.count <= QCNT_W'(QUEUE_DEPTH))
   // A pushed event leaves the queue or output stage non-empty next cycle.
   `I2CMON_ASSERT_NEXT(a_push_lands, push, !stat.empty || rsp_valid)
   // An event taken from the queue is offered on the result channel.
   `I2CMON_ASSERT_NEXT(a_pop_shows, pop, rsp_valid)

endmodule
